>>> rtl/core/tmtp_pkg.sv
// Package for the text markup tag parser: word types, kind codes, keyword
// patterns, control structs and a hex digit helper function.
// No dependencies.
`default_nettype none

package tmtp_pkg;

    localparam int TAG_MAX_DEF  = 32;
    localparam int POS_BITS_DEF = 16;

    localparam logic [1:0] PH_PLAIN = 2'd0;
    localparam logic [1:0] PH_AMP   = 2'd1;
    localparam logic [1:0] PH_TAG   = 2'd2;
    localparam logic [1:0] PH_ENDED = 2'd3;

    localparam logic [3:0] KIND_TEXT  = 4'd0;
    localparam logic [3:0] KIND_FONT  = 4'd1;
    localparam logic [3:0] KIND_IMAGE = 4'd2;
    localparam logic [3:0] KIND_FG    = 4'd3;
    localparam logic [3:0] KIND_MAIN  = 4'd4;
    localparam logic [3:0] KIND_GEOM  = 4'd5;
    localparam logic [3:0] KIND_OUTL  = 4'd6;
    localparam logic [3:0] KIND_LSP   = 4'd7;
    localparam logic [3:0] KIND_LEX   = 4'd8;
    localparam logic [3:0] KIND_JUST  = 4'd9;
    localparam logic [3:0] KIND_VJUST = 4'd10;
    localparam logic [3:0] KIND_PUSH  = 4'd11;
    localparam logic [3:0] KIND_POP   = 4'd12;

    localparam logic [15:0] CH_AMP   = 16'h0026;
    localparam logic [15:0] CH_SEMI  = 16'h003B;
    localparam logic [15:0] CH_MINUS = 16'h002D;
    localparam logic [15:0] CH_COMMA = 16'h002C;
    localparam logic [15:0] CH_ZERO  = 16'h0030;
    localparam logic [7:0]  ALPHA_DEF = 8'hff;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last;
    } in_word_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [15:0]        seg_start;
        logic [15:0]        seg_length;
        logic [31:0]        packed_value;
        logic signed [31:0] number;
        logic [2:0]         mode;
        logic               last_of_run;
    } out_word_t;

    typedef struct packed {
        logic step;
        logic decode;
        logic emit_hold;
        logic emit_cmd;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic close;
        logic hold_valid;
        logic cmd_valid;
    } dp_stat_t;

    typedef struct packed {
        logic [135:0] text;
        logic [4:0]   len;
        logic [2:0]   off;
        logic         whole;
    } pat_t;

    localparam int NPAT = 30;

    localparam int P_FONT  = 0;
    localparam int P_IMAGE = 1;
    localparam int P_FG    = 2;
    localparam int P_MAIN  = 3;
    localparam int P_GEOM  = 4;
    localparam int P_OUTL  = 5;
    localparam int P_COLOR = 6;
    localparam int P_LSP   = 7;
    localparam int P_LEX   = 8;
    localparam int P_JUST  = 9;
    localparam int P_VJUST = 10;
    localparam int P_PUSH  = 11;
    localparam int P_POP   = 12;
    localparam int P_HNAME = 13;
    localparam int P_VNAME = 20;
    localparam int P_IM_A  = 27;
    localparam int P_IM_SA = 28;
    localparam int P_IM_SI = 29;
    localparam int NNAME   = 7;

    localparam pat_t PATS [NPAT] = '{
        '{136'("font="),             5'd5,  3'd0, 1'b0},
        '{136'("image="),            5'd6,  3'd0, 1'b0},
        '{136'("fg-color="),         5'd9,  3'd0, 1'b0},
        '{136'("main-color="),       5'd11, 3'd0, 1'b0},
        '{136'("geometry-color="),   5'd15, 3'd0, 1'b0},
        '{136'("outline-color="),    5'd14, 3'd0, 1'b0},
        '{136'("color"),             5'd5,  3'd0, 1'b0},
        '{136'("line-spacing="),     5'd13, 3'd0, 1'b0},
        '{136'("line-extra-space="), 5'd17, 3'd0, 1'b0},
        '{136'("just="),             5'd5,  3'd0, 1'b0},
        '{136'("vjust="),            5'd6,  3'd0, 1'b0},
        '{136'("push"),              5'd4,  3'd0, 1'b1},
        '{136'("pop"),               5'd3,  3'd0, 1'b1},
        '{136'("left"),              5'd4,  3'd5, 1'b1},
        '{136'("center"),            5'd6,  3'd5, 1'b1},
        '{136'("right"),             5'd5,  3'd5, 1'b1},
        '{136'("full"),              5'd4,  3'd5, 1'b1},
        '{136'("nleft"),             5'd5,  3'd5, 1'b1},
        '{136'("ncenter"),           5'd7,  3'd5, 1'b1},
        '{136'("nright"),            5'd6,  3'd5, 1'b1},
        '{136'("top"),               5'd3,  3'd6, 1'b1},
        '{136'("center"),            5'd6,  3'd6, 1'b1},
        '{136'("bottom"),            5'd6,  3'd6, 1'b1},
        '{136'("full"),              5'd4,  3'd6, 1'b1},
        '{136'("ntop"),              5'd4,  3'd6, 1'b1},
        '{136'("ncenter"),           5'd7,  3'd6, 1'b1},
        '{136'("nbottom"),           5'd7,  3'd6, 1'b1},
        '{136'("A"),                 5'd1,  3'd6, 1'b0},
        '{136'("SA"),                5'd2,  3'd6, 1'b0},
        '{136'("SI"),                5'd2,  3'd6, 1'b0}
    };

    localparam int NCOL = 4;
    localparam int COL_OFF [NCOL] = '{9, 11, 15, 14};
    localparam int NDEC = 2;
    localparam int DEC_OFF [NDEC] = '{13, 17};
    localparam int FONT_OFF  = 5;
    localparam int IMAGE_OFF = 6;

    function automatic logic [3:0] hex_val(input logic [15:0] u);
        logic [15:0] d;
        d = 16'd0;
        if (u >= 16'h0030 && u <= 16'h0039) d = u - 16'h0030;
        else if (u >= 16'h0041 && u <= 16'h0046) d = u - 16'h0037;
        else if (u >= 16'h0061 && u <= 16'h0066) d = u - 16'h0057;
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/text_markup_tag_parser.sv
// Top level of the text markup tag parser: controller plus datapath.
// Depends on tmtp_pkg, tmtp_ctrl, tmtp_dp.
//
//  channel | handshake                  | word
//  --------+----------------------------+----------------------------------
//  item    | item_valid / item_stall    | code_unit, last
//  result  | result_valid / result_stall| kind, segment, value, mode, last
//
// A code unit that does not close a tag is taken in the run state; a closing
// unit then goes through a decode state and an emit state (decode, then up to
// two words: held text and command). Keyword matching and value decode run as
// each tag unit is stored, so a close only adds the decode and emit states.
// Reset returns to plain text at position 0. Input stalls in the decode and
// emit states and while the output register is full and not being taken.
`default_nettype none

module text_markup_tag_parser #(
    parameter int TAG_MAX  = tmtp_pkg::TAG_MAX_DEF,
    parameter int POS_BITS = tmtp_pkg::POS_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire tmtp_pkg::in_word_t  item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output tmtp_pkg::out_word_t      result
);

    tmtp_pkg::dp_cmd_t  cmd;
    tmtp_pkg::dp_stat_t stat;

    tmtp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    tmtp_dp #(
        .TAG_MAX  (TAG_MAX),
        .POS_BITS (POS_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .result_stall (result_stall),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> rtl/core/tmtp_dp.sv
// Datapath of the text markup tag parser: position tracking, incremental
// tag matching and value decode, held and output words.
// Depends on tmtp_pkg.
`default_nettype none

module tmtp_dp #(
    parameter int TAG_MAX  = tmtp_pkg::TAG_MAX_DEF,
    parameter int POS_BITS = tmtp_pkg::POS_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tmtp_pkg::in_word_t  item,
    input  wire tmtp_pkg::dp_cmd_t   cmd,
    input  wire logic                result_stall,
    output tmtp_pkg::dp_stat_t       stat,
    output logic                     result_valid,
    output tmtp_pkg::out_word_t      result
);

    localparam int LEN_W = $clog2(TAG_MAX + 1);

    logic [1:0]          phase_reg, phase_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] seg_reg, seg_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [tmtp_pkg::NPAT-1:0] flag_reg, flag_next;
    logic [31:0]         font_reg, font_next;
    logic [31:0]         image_reg, image_next;
    logic [31:0]         col_reg [tmtp_pkg::NCOL];
    logic [31:0]         col_next [tmtp_pkg::NCOL];
    logic [31:0]         dec_reg [tmtp_pkg::NDEC];
    logic [31:0]         dec_next [tmtp_pkg::NDEC];
    logic                neg_reg [tmtp_pkg::NDEC];
    logic                neg_next [tmtp_pkg::NDEC];
    logic                comma_reg, comma_next;

    tmtp_pkg::out_word_t hold_reg, hold_next;
    logic                hold_valid_reg, hold_valid_next;
    tmtp_pkg::out_word_t cmd_reg, cmd_next;
    logic                cmd_valid_reg, cmd_valid_next;
    tmtp_pkg::out_word_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [15:0]         c;
    logic                lst;
    logic                txt_valid;
    logic [POS_BITS-1:0] txt_len;
    logic                close;
    logic                do_store;
    logic                do_open;
    logic                end_run;
    tmtp_pkg::out_word_t txt_word;
    logic [31:0]         start32;
    logic [31:0]         len32;

    tmtp_pkg::out_word_t dec_word;
    logic                dec_valid;

    // step: phase and position
    always_comb
    begin
        c          = item.code_unit;
        lst        = item.last;
        txt_valid  = 1'b0;
        txt_len    = pos_reg - seg_reg;
        close      = 1'b0;
        do_store   = 1'b0;
        do_open    = 1'b0;
        end_run    = 1'b0;
        phase_next = phase_reg;
        seg_next   = seg_reg;
        pos_next   = pos_reg;
        unique case (phase_reg)
            tmtp_pkg::PH_ENDED:
            begin
                end_run = lst;
            end
            tmtp_pkg::PH_AMP:
            begin
                txt_valid = 1'b1;
                if (c == 16'd0)
                begin
                    txt_len = pos_reg - POS_BITS'(1) - seg_reg;
                    end_run = 1'b1;
                end
                else if (c == tmtp_pkg::CH_AMP)
                begin
                    seg_next   = pos_reg + POS_BITS'(1);
                    phase_next = tmtp_pkg::PH_PLAIN;
                    end_run    = lst;
                end
                else
                begin
                    txt_len = pos_reg - POS_BITS'(1) - seg_reg;
                    if (c == tmtp_pkg::CH_SEMI)
                    begin
                        seg_next   = pos_reg + POS_BITS'(1);
                        phase_next = tmtp_pkg::PH_PLAIN;
                        end_run    = lst;
                    end
                    else
                    begin
                        do_open    = 1'b1;
                        do_store   = 1'b1;
                        phase_next = tmtp_pkg::PH_TAG;
                        close      = lst;
                        end_run    = lst;
                    end
                end
            end
            tmtp_pkg::PH_TAG:
            begin
                if (c == 16'd0)
                begin
                    close   = 1'b1;
                    end_run = 1'b1;
                end
                else if (c == tmtp_pkg::CH_SEMI)
                begin
                    close      = 1'b1;
                    seg_next   = pos_reg + POS_BITS'(1);
                    phase_next = tmtp_pkg::PH_PLAIN;
                    end_run    = lst;
                end
                else
                begin
                    do_store = 1'b1;
                    close    = lst;
                    end_run  = lst;
                end
            end
            tmtp_pkg::PH_PLAIN:
            begin
                if (c == 16'd0)
                begin
                    txt_valid = (pos_reg != seg_reg);
                    end_run   = 1'b1;
                end
                else if (c == tmtp_pkg::CH_AMP && !lst)
                begin
                    phase_next = tmtp_pkg::PH_AMP;
                end
                else if (lst)
                begin
                    txt_valid = 1'b1;
                    txt_len   = pos_reg + POS_BITS'(1) - seg_reg;
                    end_run   = 1'b1;
                end
            end
            default:
            begin
                end_run = 1'b0;
            end
        endcase
        if (end_run && !lst)
        begin
            phase_next = tmtp_pkg::PH_ENDED;
        end
        else if (end_run)
        begin
            phase_next = tmtp_pkg::PH_PLAIN;
            pos_next   = '0;
            seg_next   = '0;
        end
        else
        begin
            pos_next = pos_reg + POS_BITS'(1);
        end
    end

    always_comb
    begin
        start32               = 32'(seg_reg);
        len32                 = 32'(txt_len);
        txt_word              = '0;
        txt_word.kind         = tmtp_pkg::KIND_TEXT;
        txt_word.seg_start    = start32[15:0];
        txt_word.seg_length   = len32[15:0];
    end

    // step: tag store and incremental match
    always_comb
    begin
        int  ii;
        int  rel;
        int  sel;
        logic [3:0]  hv;
        logic [31:0] dig;
        logic [7:0]  ch;

        len_next   = len_reg;
        flag_next  = flag_reg;
        font_next  = font_reg;
        image_next = image_reg;
        col_next   = col_reg;
        dec_next   = dec_reg;
        neg_next   = neg_reg;
        comma_next = comma_reg;
        hv         = tmtp_pkg::hex_val(c);
        dig        = 32'(c) - 32'(tmtp_pkg::CH_ZERO);
        ii         = 0;
        rel        = 0;
        sel        = 0;
        ch         = 8'd0;
        if (do_open)
        begin
            len_next   = '0;
            flag_next  = '1;
            font_next  = '0;
            image_next = '0;
            comma_next = 1'b0;
            for (int k = 0; k < tmtp_pkg::NCOL; k++)
            begin
                col_next[k] = '0;
            end
            for (int k = 0; k < tmtp_pkg::NDEC; k++)
            begin
                dec_next[k] = '0;
                neg_next[k] = 1'b0;
            end
        end
        if (do_store && int'(len_next) < TAG_MAX)
        begin
            ii = int'(len_next);
            len_next = len_next + LEN_W'(1);
            for (int p = 0; p < tmtp_pkg::NPAT; p++)
            begin
                rel = ii - int'(tmtp_pkg::PATS[p].off);
                if (rel >= 0 && rel < int'(tmtp_pkg::PATS[p].len))
                begin
                    sel = 8 * (int'(tmtp_pkg::PATS[p].len) - 1 - rel);
                end
                else
                begin
                    sel = 0;
                end
                ch = tmtp_pkg::PATS[p].text[sel +: 8];
                if (rel >= 0 && rel < int'(tmtp_pkg::PATS[p].len) && c != {8'h00, ch})
                begin
                    flag_next[p] = 1'b0;
                end
            end
            for (int k = 0; k < 8; k++)
            begin
                if (ii == tmtp_pkg::FONT_OFF + k)
                begin
                    font_next[31-4*k -: 4] = hv;
                end
                if (ii == tmtp_pkg::IMAGE_OFF + k)
                begin
                    image_next[31-4*k -: 4] = hv;
                end
                for (int j = 0; j < tmtp_pkg::NCOL; j++)
                begin
                    if (ii == tmtp_pkg::COL_OFF[j] + 1 + k)
                    begin
                        col_next[j][31-4*k -: 4] = hv;
                    end
                end
            end
            for (int j = 0; j < tmtp_pkg::NDEC; j++)
            begin
                if (ii == tmtp_pkg::DEC_OFF[j])
                begin
                    neg_next[j] = (c == tmtp_pkg::CH_MINUS);
                    dec_next[j] = (c == tmtp_pkg::CH_MINUS) ? 32'd0 : dig;
                end
                else if (ii > tmtp_pkg::DEC_OFF[j])
                begin
                    dec_next[j] = (dec_next[j] << 3) + (dec_next[j] << 1) + dig;
                end
            end
            if (ii >= tmtp_pkg::IMAGE_OFF && c == tmtp_pkg::CH_COMMA)
            begin
                comma_next = 1'b1;
            end
        end
    end

    // decode of the closed tag
    always_comb
    begin
        logic [tmtp_pkg::NPAT-1:0] pm;
        logic [31:0] colv [tmtp_pkg::NCOL];
        logic [31:0] decv [tmtp_pkg::NDEC];
        logic        found;
        int          tl;
        int          need;

        tl = int'(len_reg);
        for (int p = 0; p < tmtp_pkg::NPAT; p++)
        begin
            need = int'(tmtp_pkg::PATS[p].off) + int'(tmtp_pkg::PATS[p].len);
            pm[p] = flag_reg[p] && (tmtp_pkg::PATS[p].whole ? (tl == need) : (tl >= need));
        end
        for (int j = 0; j < tmtp_pkg::NCOL; j++)
        begin
            colv[j] = {col_reg[j][31:8],
                       (tl == tmtp_pkg::COL_OFF[j] + 9) ? col_reg[j][7:0]
                                                         : tmtp_pkg::ALPHA_DEF};
        end
        for (int j = 0; j < tmtp_pkg::NDEC; j++)
        begin
            decv[j] = neg_reg[j] ? (32'd0 - dec_reg[j]) : dec_reg[j];
        end
        dec_word  = '0;
        dec_valid = 1'b0;
        found     = 1'b0;
        dec_word.last_of_run = 1'b1;
        priority if (pm[tmtp_pkg::P_FONT])
        begin
            dec_valid             = 1'b1;
            dec_word.kind         = tmtp_pkg::KIND_FONT;
            dec_word.packed_value = font_reg;
        end
        else if (pm[tmtp_pkg::P_IMAGE])
        begin
            dec_valid = !(comma_reg && (pm[tmtp_pkg::P_IM_A] || pm[tmtp_pkg::P_IM_SA]
                                        || pm[tmtp_pkg::P_IM_SI]));
            dec_word.kind         = tmtp_pkg::KIND_IMAGE;
            dec_word.packed_value = image_reg;
        end
        else if (pm[tmtp_pkg::P_FG])
        begin
            dec_valid             = 1'b1;
            dec_word.kind         = tmtp_pkg::KIND_FG;
            dec_word.packed_value = colv[0];
        end
        else if (pm[tmtp_pkg::P_MAIN])
        begin
            dec_valid             = 1'b1;
            dec_word.kind         = tmtp_pkg::KIND_MAIN;
            dec_word.packed_value = colv[1];
        end
        else if (pm[tmtp_pkg::P_GEOM])
        begin
            dec_valid             = 1'b1;
            dec_word.kind         = tmtp_pkg::KIND_GEOM;
            dec_word.packed_value = colv[2];
        end
        else if (pm[tmtp_pkg::P_OUTL])
        begin
            dec_valid             = 1'b1;
            dec_word.kind         = tmtp_pkg::KIND_OUTL;
            dec_word.packed_value = colv[3];
        end
        else if (pm[tmtp_pkg::P_COLOR])
        begin
            dec_valid = 1'b0;
        end
        else if (pm[tmtp_pkg::P_LSP])
        begin
            dec_valid       = 1'b1;
            dec_word.kind   = tmtp_pkg::KIND_LSP;
            dec_word.number = decv[0];
        end
        else if (pm[tmtp_pkg::P_LEX])
        begin
            dec_valid       = 1'b1;
            dec_word.kind   = tmtp_pkg::KIND_LEX;
            dec_word.number = decv[1];
        end
        else if (pm[tmtp_pkg::P_JUST])
        begin
            dec_word.kind = tmtp_pkg::KIND_JUST;
            for (int h = 0; h < tmtp_pkg::NNAME; h++)
            begin
                if (!found && pm[tmtp_pkg::P_HNAME + h])
                begin
                    found         = 1'b1;
                    dec_word.mode = 3'(h);
                end
            end
            dec_valid = found;
        end
        else if (pm[tmtp_pkg::P_VJUST])
        begin
            dec_word.kind = tmtp_pkg::KIND_VJUST;
            for (int h = 0; h < tmtp_pkg::NNAME; h++)
            begin
                if (!found && pm[tmtp_pkg::P_VNAME + h])
                begin
                    found         = 1'b1;
                    dec_word.mode = 3'(h);
                end
            end
            dec_valid = found;
        end
        else if (pm[tmtp_pkg::P_PUSH])
        begin
            dec_valid     = 1'b1;
            dec_word.kind = tmtp_pkg::KIND_PUSH;
        end
        else if (pm[tmtp_pkg::P_POP])
        begin
            dec_valid     = 1'b1;
            dec_word.kind = tmtp_pkg::KIND_POP;
        end
    end

    // held text, decoded command, output register
    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        cmd_next        = cmd_reg;
        cmd_valid_next  = cmd_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && result_stall;
        if (cmd.step && close)
        begin
            hold_next       = txt_word;
            hold_valid_next = txt_valid;
        end
        if (cmd.decode)
        begin
            cmd_next       = dec_word;
            cmd_valid_next = dec_valid;
        end
        if (cmd.step && !close && txt_valid)
        begin
            out_next             = txt_word;
            out_next.last_of_run = 1'b1;
            out_valid_next       = 1'b1;
        end
        else if (cmd.emit_hold)
        begin
            out_next             = hold_reg;
            out_next.last_of_run = !cmd_valid_reg;
            out_valid_next       = 1'b1;
            hold_valid_next      = 1'b0;
        end
        else if (cmd.emit_cmd)
        begin
            out_next       = cmd_reg;
            out_valid_next = 1'b1;
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tmtp_pkg::PH_PLAIN;
            pos_reg        <= '0;
            seg_reg        <= '0;
            len_reg        <= '0;
            hold_valid_reg <= 1'b0;
            cmd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.step)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                seg_reg   <= seg_next;
                len_reg   <= len_next;
            end
            hold_valid_reg <= hold_valid_next;
            cmd_valid_reg  <= cmd_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            flag_reg  <= flag_next;
            font_reg  <= font_next;
            image_reg <= image_next;
            col_reg   <= col_next;
            dec_reg   <= dec_next;
            neg_reg   <= neg_next;
            comma_reg <= comma_next;
        end
        hold_reg <= hold_next;
        cmd_reg  <= cmd_next;
        out_reg  <= out_next;
    end

    assign stat.out_free   = !out_valid_reg || !result_stall;
    assign stat.close      = close;
    assign stat.hold_valid = hold_valid_reg;
    assign stat.cmd_valid  = cmd_valid_reg;
    assign result_valid    = out_valid_reg;
    assign result          = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/tmtp_ctrl.sv
// Controller of the text markup tag parser: accepts words, sequences tag
// decode and the emission of held text and command words.
// Depends on tmtp_pkg.
`default_nettype none

module tmtp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire tmtp_pkg::dp_stat_t stat,
    output tmtp_pkg::dp_cmd_t       cmd
);

    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            ST_RUN:
            begin
                item_stall = !stat.out_free;
                cmd.step   = item_valid && stat.out_free;
                if (cmd.step && stat.close)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (stat.hold_valid)
                    begin
                        cmd.emit_hold = 1'b1;
                        if (!stat.cmd_valid)
                        begin
                            state_next = ST_RUN;
                        end
                    end
                    else
                    begin
                        cmd.emit_cmd = stat.cmd_valid;
                        state_next   = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
